// File: design/capnorm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture sample normaliser package
// Shared types, register indices, format codes and constants.
// ----------------------------------------------------------------------------
package capnorm_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VALID_BITS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEREO_SOURCE = 2'd2;

    typedef enum logic [1:0] {
        FMT_PCM16   = 2'd0,
        FMT_PCM24   = 2'd1,
        FMT_PCM32   = 2'd2,
        FMT_FLOAT32 = 2'd3
    } fmt_t;

    localparam logic [5:0]  VALID_BITS_FULL = 6'd32;
    localparam logic [23:0] Q_ONE           = 24'h80_0000;
    localparam logic [23:0] Q_MAX           = 24'h7F_FFFF;
    localparam logic [7:0]  EXP_BIAS        = 8'd127;
    localparam logic [7:0]  EXP_SPECIAL     = 8'hFF;

    // sign and magnitude in units of 2^-23, magnitude up to Q_ONE
    typedef struct packed {
        logic        neg;
        logic [23:0] mag;
    } fix_t;

    typedef struct packed {
        logic [31:0] left_word;
        logic [31:0] right_word;
        logic        silent;
        logic        packet_end;
    } in_word_t;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
        logic [23:0]        left_peak;
        logic [23:0]        right_peak;
        logic               last_of_packet;
    } out_word_t;

    // +1.0 saturates to the largest positive code
    function automatic logic signed [23:0] to_sample(fix_t v);
        logic [23:0] s;
        if (v.neg)
            s = 24'd0 - v.mag;
        else if (v.mag >= Q_ONE)
            s = Q_MAX;
        else
            s = v.mag;
        return $signed(s);
    endfunction

endpackage

// File: design/capnorm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture sample normaliser channels
// Valid/ready channels for input frames and result words.
// ----------------------------------------------------------------------------
interface capnorm_in_if;
    import capnorm_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface capnorm_out_if;
    import capnorm_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/capnorm_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture sample decoder
// Turns one raw container word into sign and Q1.23 magnitude.
// ----------------------------------------------------------------------------
module capnorm_decode (
    input  logic [31:0]        word,
    input  capnorm_pkg::fmt_t  fmt,
    input  logic [5:0]         valid_bits,
    output capnorm_pkg::fix_t  val
);
    import capnorm_pkg::*;

    logic [5:0]  vb_eff;
    logic [5:0]  drop;
    logic [31:0] keep_mask;
    logic [31:0] pcm_top;
    logic [31:0] pcm_abs;
    logic [7:0]  exp_f;
    logic [22:0] man_f;
    logic [7:0]  shift_f;
    logic [23:0] flt_mag;

    // PCM: place the sample at the top of a 32-bit word, so every width
    // becomes a fraction of 2^31 and the magnitude is simply bits [31:8].
    always_comb
    begin
        vb_eff = (valid_bits == 6'd0 || valid_bits > VALID_BITS_FULL)
                 ? VALID_BITS_FULL : valid_bits;
        drop      = VALID_BITS_FULL - vb_eff;
        keep_mask = 32'hFFFF_FFFF << drop[4:0];
        case (fmt)
            FMT_PCM16: pcm_top = {word[15:0], 16'h0000};
            FMT_PCM24: pcm_top = {word[23:0], 8'h00};
            FMT_PCM32: pcm_top = word & keep_mask;
            default:   pcm_top = 32'd0;
        endcase
        pcm_abs = pcm_top[31] ? (32'd0 - pcm_top) : pcm_top;
    end

    always_comb
    begin
        exp_f   = word[30:23];
        man_f   = word[22:0];
        shift_f = EXP_BIAS - exp_f;
        if (exp_f == 8'd0 || (exp_f == EXP_SPECIAL && man_f != 23'd0))
            flt_mag = 24'd0;
        else if (exp_f >= EXP_BIAS)
            flt_mag = Q_ONE;
        else if (shift_f >= 8'd24)
            flt_mag = 24'd0;
        else
            flt_mag = {1'b1, man_f} >> shift_f[4:0];
    end

    always_comb
    begin
        if (fmt == FMT_FLOAT32)
        begin
            val.mag = flt_mag;
            val.neg = word[31] && (flt_mag != 24'd0);
        end
        else
        begin
            val.mag = pcm_abs[31:8];
            val.neg = pcm_top[31] && (pcm_abs[31:8] != 24'd0);
        end
    end

endmodule

// File: design/capture_sample_normalizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture sample normaliser
// Decodes captured PCM or float frames into Q1.23 samples with packet peaks.
// ----------------------------------------------------------------------------
// Use:
//   frame  : valid/ready input, one word per captured stereo frame.
//   result : valid/ready output, one word per frame, in order.
//   cfg_*  : write-only registers (format, valid bits, stereo source);
//            write them only while no frame is in flight.
// Throughput: one frame per cycle while result keeps taking words; an
//   accepted frame is registered in the frame register, which feeds a
//   single decode/peak stage into the result register.
// The peak holds advance as a frame moves into the result register and are
//   cleared after the frame marked as packet end.
// Reset: both stages empty, peaks zero, format float32, 32 valid bits,
//   stereo source.
// Stall: when result is not taken the result register holds, the frame
//   register still fills once, then frame.ready drops.
// ----------------------------------------------------------------------------
module capture_sample_normalizer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [capnorm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [capnorm_pkg::CFG_DATA_W-1:0]  cfg_data,
    capnorm_in_if.sink                          frame,
    capnorm_out_if.source                       result
);
    import capnorm_pkg::*;

    fmt_t        fmt_reg, fmt_next;
    logic [5:0]  vbits_reg, vbits_next;
    logic        stereo_reg, stereo_next;

    logic        s1_valid_reg, s1_valid_next;
    in_word_t    s1_data_reg, s1_data_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_data_reg, out_data_next;
    logic [23:0] lpeak_reg, lpeak_next;
    logic [23:0] rpeak_reg, rpeak_next;

    logic        s1_adv;
    logic        in_take;
    fix_t        dec_l, dec_r;
    fix_t        val_l, val_r;
    logic [23:0] lpeak_new, rpeak_new;

    capnorm_decode u_dec_left (
        .word       (s1_data_reg.left_word),
        .fmt        (fmt_reg),
        .valid_bits (vbits_reg),
        .val        (dec_l)
    );

    capnorm_decode u_dec_right (
        .word       (s1_data_reg.right_word),
        .fmt        (fmt_reg),
        .valid_bits (vbits_reg),
        .val        (dec_r)
    );

    assign s1_adv       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready  = !s1_valid_reg || s1_adv;
    assign in_take      = frame.valid && frame.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_comb
    begin
        fmt_next    = fmt_reg;
        vbits_next  = vbits_reg;
        stereo_next = stereo_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_FORMAT: fmt_next    = fmt_t'(cfg_data[1:0]);
                REG_VALID_BITS:    vbits_next  = cfg_data[5:0];
                REG_STEREO_SOURCE: stereo_next = cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (s1_data_reg.silent)
        begin
            val_l = '0;
            val_r = '0;
        end
        else
        begin
            val_l = dec_l;
            val_r = stereo_reg ? dec_r : dec_l;
        end
        lpeak_new = (val_l.mag > lpeak_reg) ? val_l.mag : lpeak_reg;
        rpeak_new = (val_r.mag > rpeak_reg) ? val_r.mag : rpeak_reg;

        s1_valid_next  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s1_data_next   = in_take ? frame.data : s1_data_reg;
        out_valid_next = s1_adv ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

        out_data_next = out_data_reg;
        lpeak_next    = lpeak_reg;
        rpeak_next    = rpeak_reg;
        if (s1_adv)
        begin
            out_data_next.left_sample    = to_sample(val_l);
            out_data_next.right_sample   = to_sample(val_r);
            out_data_next.left_peak      = lpeak_new;
            out_data_next.right_peak     = rpeak_new;
            out_data_next.last_of_packet = s1_data_reg.packet_end;
            lpeak_next = s1_data_reg.packet_end ? 24'd0 : lpeak_new;
            rpeak_next = s1_data_reg.packet_end ? 24'd0 : rpeak_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_FLOAT32;
            vbits_reg     <= VALID_BITS_FULL;
            stereo_reg    <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lpeak_reg     <= 24'd0;
            rpeak_reg     <= 24'd0;
        end
        else
        begin
            fmt_reg       <= fmt_next;
            vbits_reg     <= vbits_next;
            stereo_reg    <= stereo_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            lpeak_reg     <= lpeak_next;
            rpeak_reg     <= rpeak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg  <= s1_data_next;
        out_data_reg <= out_data_next;
    end

    // peaks never exceed full scale
    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.left_peak <= Q_ONE &&
                           out_data_reg.right_peak <= Q_ONE))
        else $error("peak above full scale");

    // a non-negative left sample is covered by its peak
    a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.left_sample[23]) |->
            (out_data_reg.left_peak >= out_data_reg.left_sample[23:0]))
        else $error("left peak below sample");

    // holds clear once the packet-end word moves on
    a_peak_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_data_reg.packet_end) |=>
            (lpeak_reg == 24'd0 && rpeak_reg == 24'd0))
        else $error("peak hold not cleared after packet end");

    // both stages full and result stalled: no new frame may enter
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result.ready) |-> !frame.ready)
        else $error("frame accepted while pipeline full");

    // a stalled result word is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> (out_valid_reg &&
                                               $stable(out_data_reg)))
        else $error("result word changed under stall");

endmodule

// File: bench/tb_capture_sample_normalizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Capture sample normaliser testbench
// A table of directed frames covers each sample format, the float specials,
// saturation, odd valid_bits settings, mono and silent frames. Random phases
// follow, one per register setting. Every result word is checked field by
// field against the expected values of its table row or a local model of
// the decode and peak logic, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_capture_sample_normalizer_top;
    import capnorm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 16;
    localparam int PHASE_FRAMES   = 95;

    localparam logic [31:0] CORNER_WORDS [0:14] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0000_8000, 32'h0000_7FFF, 32'h0080_0000, 32'h007F_FFFF,
        32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0000, 32'h0000_0001, 32'h8000_0001
    };

    // sign and magnitude, magnitude in units of 2^-23 up to 1.0
    typedef struct packed {
        logic        neg;
        logic [23:0] mag;
    } level_t;

    typedef struct {
        fmt_t      fmt;
        logic [5:0] vbits;
        logic      stereo;
        in_word_t  fw;
        bit        typed;
        out_word_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    capnorm_in_if  frame_ch ();
    capnorm_out_if result_ch ();

    capture_sample_normalizer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame_ch),
        .result    (result_ch)
    );

    // register mirror and peak holds of the model
    fmt_t        cur_fmt    = FMT_FLOAT32;
    logic [5:0]  cur_vb     = VALID_BITS_FULL;
    logic        cur_stereo = 1'b1;
    logic [23:0] left_peak_hold  = '0;
    logic [23:0] right_peak_hold = '0;

    out_word_t   pending_results [$];
    dir_row_t    directed_rows [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic level_t pcm_to_level(logic [31:0] raw, int unsigned bits);
        logic [63:0] span;
        logic [63:0] v;
        logic [63:0] m;
        level_t      r;
        span  = 64'd1 << bits;
        v     = {32'd0, raw} & (span - 64'd1);
        r.neg = v[bits-1];
        m     = r.neg ? span - v : v;
        if (bits <= 24)
            m = m << (24 - bits);
        else
            m = m >> (bits - 24);
        r.mag = m[23:0];
        if (r.mag == '0)
            r.neg = 1'b0;
        return r;
    endfunction

    function automatic level_t float_to_level(logic [31:0] w);
        logic [7:0]  ex;
        logic [22:0] fr;
        int unsigned sh;
        level_t      r;
        ex    = w[30:23];
        fr    = w[22:0];
        r.neg = w[31];
        if (ex == '0 || (ex == EXP_SPECIAL && fr != '0))
            r.mag = '0;
        else if (ex >= EXP_BIAS)
            r.mag = Q_ONE;
        else
        begin
            sh    = EXP_BIAS - ex;
            r.mag = (sh >= 24) ? 24'd0 : ({1'b1, fr} >> sh);
        end
        if (r.mag == '0)
            r.neg = 1'b0;
        return r;
    endfunction

    function automatic level_t word_to_level(logic [31:0] w);
        int unsigned vb;
        case (cur_fmt)
            FMT_PCM16: return pcm_to_level(w, 16);
            FMT_PCM24: return pcm_to_level(w, 24);
            FMT_PCM32:
            begin
                vb = cur_vb;
                if (vb == 0 || vb > 32)
                    vb = 32;
                return pcm_to_level(w >> (32 - vb), vb);
            end
            default:   return float_to_level(w);
        endcase
    endfunction

    // +1.0 saturates, -1.0 is representable
    function automatic logic [23:0] level_to_q123(level_t v);
        if (v.neg)
            return 24'd0 - v.mag;
        if (v.mag >= Q_ONE)
            return Q_MAX;
        return v.mag;
    endfunction

    function automatic out_word_t normalise_frame(in_word_t f);
        level_t    l;
        level_t    r;
        out_word_t o;
        if (f.silent)
        begin
            l = '0;
            r = '0;
        end
        else
        begin
            l = word_to_level(f.left_word);
            r = cur_stereo ? word_to_level(f.right_word) : l;
        end
        if (l.mag > left_peak_hold)
            left_peak_hold = l.mag;
        if (r.mag > right_peak_hold)
            right_peak_hold = r.mag;
        o.left_sample    = level_to_q123(l);
        o.right_sample   = level_to_q123(r);
        o.left_peak      = left_peak_hold;
        o.right_peak     = right_peak_hold;
        o.last_of_packet = f.packet_end;
        if (f.packet_end)
        begin
            left_peak_hold  = '0;
            right_peak_hold = '0;
        end
        return o;
    endfunction

    function automatic void add_row(fmt_t fm, logic [5:0] vbits, logic st,
                                    logic [31:0] lw, logic [31:0] rw, logic sil,
                                    logic pe, bit typed, logic [23:0] ls,
                                    logic [23:0] rs, logic [23:0] lp,
                                    logic [23:0] rp);
        dir_row_t row;
        row.fmt                 = fm;
        row.vbits               = vbits;
        row.stereo              = st;
        row.fw.left_word        = lw;
        row.fw.right_word       = rw;
        row.fw.silent           = sil;
        row.fw.packet_end       = pe;
        row.typed               = typed;
        row.want.left_sample    = ls;
        row.want.right_sample   = rs;
        row.want.left_peak      = lp;
        row.want.right_peak     = rp;
        row.want.last_of_packet = pe;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic logic [31:0] draw_word();
        case ($urandom_range(0, 9))
            5, 6, 7: return {1'($urandom_range(0, 1)), 8'($urandom_range(100, 127)),
                             23'($urandom)};
            8, 9:    return CORNER_WORDS[$urandom_range(0, 14)];
            default: return $urandom;
        endcase
    endfunction

    task automatic push_frame(in_word_t w, bit typed, out_word_t want);
        int unsigned gap;
        out_word_t   predicted;
        gap = send_calm ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 31) == 0)
            send_calm = !send_calm;
        if (gap != 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_ch.valid <= 1'b1;
        frame_ch.data  <= w;
        do @(posedge clk); while (!frame_ch.ready);
        predicted = normalise_frame(w);
        pending_results = {pending_results, (typed ? want : predicted)};
    endtask

    // hold off until every word is back, then allow for the pipeline
    task automatic settle();
        frame_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(fmt_t f, logic [5:0] vb, logic st);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SAMPLE_FORMAT;
        cfg_data  <= {4'd0, f};
        @(posedge clk);
        cfg_index <= REG_VALID_BITS;
        cfg_data  <= vb;
        @(posedge clk);
        cfg_index <= REG_STEREO_SOURCE;
        cfg_data  <= {5'd0, st};
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_fmt    = f;
        cur_vb     = vb;
        cur_stereo = st;
    endtask

    task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, got %h",
                         $time, result_ch.data);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("left_sample", want.left_sample, result_ch.data.left_sample);
                check_field("right_sample", want.right_sample, result_ch.data.right_sample);
                check_field("left_peak", want.left_peak, result_ch.data.left_peak);
                check_field("right_peak", want.right_peak, result_ch.data.right_peak);
                check_field("last_of_packet", {23'd0, want.last_of_packet},
                            {23'd0, result_ch.data.last_of_packet});
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // result side: random stalls with calm stretches
    initial
    begin : result_drain
        int unsigned stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = recv_calm ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 31) == 0)
                recv_calm = !recv_calm;
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    initial
    begin : stimulus
        dir_row_t    row;
        in_word_t    w;
        fmt_t        f;
        logic [5:0]  vb;
        logic        st;
        out_word_t   none;
        int unsigned p;
        int unsigned n;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        frame_ch.valid <= 1'b0;
        frame_ch.data  <= '0;
        none = '0;

        // float specials at reset settings
        add_row(FMT_FLOAT32, 6'd32, 1'b1, 32'h3F80_0000, 32'hBF80_0000, 1'b0, 1'b1, 1'b1,
                24'h7F_FFFF, 24'h80_0000, 24'h80_0000, 24'h80_0000);
        add_row(FMT_FLOAT32, 6'd32, 1'b1, 32'h7FC0_0000, 32'h0000_0001, 1'b0, 1'b1, 1'b1,
                24'h0, 24'h0, 24'h0, 24'h0);
        add_row(FMT_FLOAT32, 6'd32, 1'b1, 32'h7F80_0000, 32'hFF80_0000, 1'b0, 1'b1, 1'b1,
                24'h7F_FFFF, 24'h80_0000, 24'h80_0000, 24'h80_0000);
        add_row(FMT_FLOAT32, 6'd32, 1'b1, 32'h3F00_0000, 32'hBF00_0000, 1'b0, 1'b0, 1'b1,
                24'h40_0000, 24'hC0_0000, 24'h40_0000, 24'h40_0000);
        // silent frame keeps the held peaks
        add_row(FMT_FLOAT32, 6'd32, 1'b1, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 1'b1, 1'b1,
                24'h0, 24'h0, 24'h40_0000, 24'h40_0000);
        add_row(FMT_FLOAT32, 6'd32, 1'b1, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b1,
                24'h0, 24'h0, 24'h0, 24'h0);
        add_row(FMT_FLOAT32, 6'd32, 1'b1, 32'h3400_0000, 32'hB380_0000, 1'b0, 1'b1, 1'b1,
                24'h1, 24'h0, 24'h1, 24'h0);
        add_row(FMT_FLOAT32, 6'd32, 1'b1, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b0, 1'b1, 1'b1,
                24'h7F_FFFF, 24'h80_0000, 24'h80_0000, 24'h80_0000);
        add_row(FMT_FLOAT32, 6'd32, 1'b1, 32'h3EAA_AAAB, 32'hC049_0FDB, 1'b0, 1'b0, 1'b0,
                '0, '0, '0, '0);
        add_row(FMT_FLOAT32, 6'd32, 1'b1, 32'h0080_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0,
                '0, '0, '0, '0);
        // narrow containers ignore the upper bits
        add_row(FMT_PCM16, 6'd32, 1'b1, 32'h0000_8000, 32'h0000_7FFF, 1'b0, 1'b1, 1'b1,
                24'h80_0000, 24'h7F_FF00, 24'h80_0000, 24'h7F_FF00);
        add_row(FMT_PCM16, 6'd32, 1'b1, 32'hFFFF_0001, 32'h1234_FFFF, 1'b0, 1'b1, 1'b1,
                24'h00_0100, 24'hFF_FF00, 24'h00_0100, 24'h00_0100);
        add_row(FMT_PCM24, 6'd32, 1'b1, 32'h0080_0000, 32'hFF7F_FFFF, 1'b0, 1'b1, 1'b1,
                24'h80_0000, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF);
        add_row(FMT_PCM24, 6'd32, 1'b1, 32'h1234_5678, 32'hABCD_EF01, 1'b0, 1'b0, 1'b0,
                '0, '0, '0, '0);
        // pcm32: truncation of the dropped bits, odd valid_bits values
        add_row(FMT_PCM32, 6'd32, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1,
                24'h80_0000, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF);
        add_row(FMT_PCM32, 6'd32, 1'b1, 32'hFFFF_FFFF, 32'h0000_0100, 1'b0, 1'b1, 1'b1,
                24'h0, 24'h1, 24'h0, 24'h1);
        add_row(FMT_PCM32, 6'd1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1,
                24'h80_0000, 24'h0, 24'h80_0000, 24'h0);
        add_row(FMT_PCM32, 6'd0, 1'b1, 32'h8000_0000, 32'h0000_0100, 1'b0, 1'b1, 1'b1,
                24'h80_0000, 24'h1, 24'h80_0000, 24'h1);
        add_row(FMT_PCM32, 6'd63, 1'b1, 32'h7FFF_FFFF, 32'h8000_0001, 1'b0, 1'b1, 1'b0,
                '0, '0, '0, '0);
        add_row(FMT_PCM32, 6'd24, 1'b1, 32'h8000_0100, 32'hFFFF_FF00, 1'b0, 1'b0, 1'b0,
                '0, '0, '0, '0);
        add_row(FMT_PCM32, 6'd25, 1'b1, 32'h8000_0080, 32'hFFFF_FF80, 1'b0, 1'b1, 1'b0,
                '0, '0, '0, '0);
        // mono copies left to right
        add_row(FMT_FLOAT32, 6'd32, 1'b0, 32'hBF80_0000, 32'h3F80_0000, 1'b0, 1'b1, 1'b1,
                24'h80_0000, 24'h80_0000, 24'h80_0000, 24'h80_0000);
        add_row(FMT_FLOAT32, 6'd32, 1'b0, 32'h3F40_0000, 32'h1234_5678, 1'b0, 1'b0, 1'b0,
                '0, '0, '0, '0);
        add_row(FMT_FLOAT32, 6'd32, 1'b0, 32'hC000_0000, 32'h4000_0000, 1'b1, 1'b1, 1'b0,
                '0, '0, '0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.fmt != cur_fmt || row.vbits != cur_vb || row.stereo != cur_stereo)
            begin
                settle();
                set_config(row.fmt, row.vbits, row.stereo);
            end
            push_frame(row.fw, row.typed, row.want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            f  = fmt_t'(2'(p % 4));
            st = ((p / 4) % 2 == 0);
            if (f == FMT_PCM32)
            begin
                case (p / 4)
                    0:       vb = 6'd1;
                    1:       vb = 6'd32;
                    2:       vb = 6'd25;
                    default: vb = 6'($urandom_range(2, 31));
                endcase
            end
            else
                vb = 6'($urandom_range(0, 63));
            settle();
            set_config(f, vb, st);
            for (n = 0; n < PHASE_FRAMES; n++)
            begin
                w.left_word  = draw_word();
                w.right_word = draw_word();
                w.silent     = ($urandom_range(0, 11) == 0);
                w.packet_end = ($urandom_range(0, 7) == 0);
                push_frame(w, 1'b0, none);
            end
        end

        settle();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: capture_sample_normalizer_top.f
design/capnorm_pkg.sv
design/capnorm_if.sv
design/capnorm_decode.sv
design/capture_sample_normalizer_top.sv
bench/tb_capture_sample_normalizer_top.sv
